>>> sv/grade_set_mean_median_mode_unit_defines.svh
// Assertion macros shared by the grade statistics unit.
`ifndef GRADE_SET_MEAN_MEDIAN_MODE_UNIT_DEFINES_SVH
`define GRADE_SET_MEAN_MEDIAN_MODE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define GSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grade statistics assertion failed");
// Next-cycle implication
`define GSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grade statistics assertion failed");
`else
`define GSM_ASSERT_IMP(lbl, ante, cons)
`define GSM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/gsm_pkg.sv
package gsm_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int GRADE_W   = 16;
    localparam int SUM_W     = GRADE_W + ADDR_W;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_INDEX   = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              drop;
        logic              clear_set;
        logic              div_start;
        logic              div_step;
        logic              rd_issue;
        logic              cap_gi;
        logic              eval;
        logic              first_eval;
        logic              out_sum;
        logic              out_idx;
        logic [ADDR_W-1:0] rd_addr;
    } gsm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             full;
        logic             out_free;
        logic             match;
        logic             last_emit;
    } gsm_stat_t;

endpackage

>>> sv/gsm_in_if.sv
interface gsm_in_if;
    import gsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [GRADE_W-1:0] grade;
    logic               last;

    modport source (output valid, output grade, output last, input ready);
    modport sink   (input valid, input grade, input last, output ready);
endinterface

>>> sv/gsm_out_if.sv
interface gsm_out_if;
    import gsm_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [GRADE_W-1:0] mean_value;
    logic [GRADE_W-1:0] median_value;
    logic [GRADE_W-1:0] mode_value;
    logic [CNT_W-1:0]   mode_count;
    logic [ADDR_W-1:0]  student_index;
    logic               overflow;
    logic               end_of_run;

    modport source (output valid, output kind, output mean_value, output median_value,
                    output mode_value, output mode_count, output student_index,
                    output overflow, output end_of_run, input ready);
    modport sink   (input valid, input kind, input mean_value, input median_value,
                    input mode_value, input mode_count, input student_index,
                    input overflow, input end_of_run, output ready);
endinterface

>>> sv/gsm_ram.sv
module gsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/gsm_dp.sv
module gsm_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [gsm_pkg::GRADE_W-1:0] grade,
    input  gsm_pkg::gsm_cmd_t        cmd,
    output gsm_pkg::gsm_stat_t       stat,
    gsm_out_if.source                result
);
    import gsm_pkg::*;

    logic [GRADE_W-1:0] rdata;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               drop_reg;
    logic [SUM_W-1:0]   q_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W:0]     rem_sh;
    logic               cmp_v_reg;
    logic [GRADE_W-1:0] gi_reg;
    logic [CNT_W-1:0]   lt_reg;
    logic [CNT_W-1:0]   eq_reg;
    logic [CNT_W-1:0]   best_reg;
    logic [GRADE_W-1:0] mv_reg;
    logic [GRADE_W-1:0] med_lo_reg;
    logic [GRADE_W-1:0] med_hi_reg;
    logic [CNT_W-1:0]   emit_reg;
    logic [CNT_W-1:0]   m_hi;
    logic [CNT_W-1:0]   m_lo;
    logic [CNT_W:0]     lt_eq;
    logic               mode_upd;
    logic [GRADE_W:0]   med_sum;
    logic               valid_reg;

    gsm_ram #(.WIDTH(GRADE_W), .DEPTH(MAX_ITEMS)) u_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (grade),
        .raddr (cmd.rd_addr),
        .rdata (rdata)
    );

    // Set accumulation: count, sum, drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.clear_set)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(grade);
            end
            if (cmd.drop)
            begin
                drop_reg <= 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // Final grade is summed in the same cycle it is stored
            q_reg   <= cmd.load ? SUM_W'(sum_reg + SUM_W'(grade)) : sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, cnt_reg})
            begin
                rem_reg <= CNT_W'(rem_sh - {1'b0, cnt_reg});
                q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[CNT_W-1:0];
                q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Read-data valid for the inner compare pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= cmd.rd_issue;
        end
    end

    // Rank counting of the current pivot grade
    always_ff @(posedge clk)
    begin
        if (cmd.cap_gi)
        begin
            gi_reg <= rdata;
            lt_reg <= '0;
            eq_reg <= '0;
        end
        else if (cmp_v_reg)
        begin
            if (rdata < gi_reg)
            begin
                lt_reg <= lt_reg + 1'b1;
            end
            if (rdata == gi_reg)
            begin
                eq_reg <= eq_reg + 1'b1;
            end
        end
    end

    // Median ranks and mode choice
    assign m_hi     = cnt_reg >> 1;
    assign m_lo     = cnt_reg[0] ? m_hi : CNT_W'(m_hi - 1'b1);
    assign lt_eq    = {1'b0, lt_reg} + {1'b0, eq_reg};
    assign mode_upd = cmd.first_eval || (eq_reg > best_reg) ||
                      ((eq_reg == best_reg) && (gi_reg < mv_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            if (mode_upd)
            begin
                best_reg <= eq_reg;
                mv_reg   <= gi_reg;
            end
            if ((lt_reg <= m_lo) && ({1'b0, m_lo} < lt_eq))
            begin
                med_lo_reg <= gi_reg;
            end
            if ((lt_reg <= m_hi) && ({1'b0, m_hi} < lt_eq))
            begin
                med_hi_reg <= gi_reg;
            end
        end
    end

    assign med_sum = {1'b0, med_lo_reg} + {1'b0, med_hi_reg};

    // Emitted index count
    always_ff @(posedge clk)
    begin
        if (cmd.out_sum)
        begin
            emit_reg <= '0;
        end
        else if (cmd.out_idx)
        begin
            emit_reg <= emit_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_sum || cmd.out_idx)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_sum || cmd.out_idx)
        begin
            result.kind          <= cmd.out_sum ? KIND_SUMMARY : KIND_INDEX;
            result.mean_value    <= q_reg[GRADE_W-1:0];
            result.median_value  <= med_sum[GRADE_W:1];
            result.mode_value    <= mv_reg;
            result.mode_count    <= best_reg;
            result.student_index <= cmd.out_sum ? '0 : cmd.rd_addr;
            result.overflow      <= drop_reg;
            result.end_of_run    <= cmd.out_idx && stat.last_emit;
        end
    end

    assign result.valid   = valid_reg;

    assign stat.n         = cnt_reg;
    assign stat.full      = (cnt_reg == CNT_W'(MAX_ITEMS));
    assign stat.out_free  = !valid_reg || result.ready;
    assign stat.match     = (rdata == mv_reg);
    assign stat.last_emit = (CNT_W'(emit_reg + 1'b1) == best_reg);
endmodule

>>> sv/gsm_ctrl.sv
module gsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    input  gsm_pkg::gsm_stat_t stat,
    output gsm_pkg::gsm_cmd_t  cmd
);
    import gsm_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ORD   = 4'd2;
    localparam logic [3:0] S_OCAP  = 4'd3;
    localparam logic [3:0] S_INNER = 4'd4;
    localparam logic [3:0] S_IEND  = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_OSUM  = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCHK  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            step_reg  <= step_next;
        end
    end

    // Sequencer: load, divide, rank pass, emit
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = !stat.full;
                    cmd.drop = stat.full;
                    if (in_last)
                    begin
                        cmd.div_start = 1'b1;
                        step_next     = '0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    i_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                cmd.rd_addr = i_reg[ADDR_W-1:0];
                state_next  = S_OCAP;
            end
            S_OCAP:
            begin
                cmd.cap_gi = 1'b1;
                j_next     = '0;
                state_next = S_INNER;
            end
            S_INNER:
            begin
                cmd.rd_addr  = j_reg[ADDR_W-1:0];
                cmd.rd_issue = 1'b1;
                j_next       = j_reg + 1'b1;
                if (CNT_W'(j_reg + 1'b1) == stat.n)
                begin
                    state_next = S_IEND;
                end
            end
            S_IEND:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval       = 1'b1;
                cmd.first_eval = (i_reg == '0);
                i_next         = i_reg + 1'b1;
                state_next     = (CNT_W'(i_reg + 1'b1) == stat.n) ? S_OSUM : S_ORD;
            end
            S_OSUM:
            begin
                if (stat.out_free)
                begin
                    cmd.out_sum = 1'b1;
                    j_next      = '0;
                    state_next  = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.rd_addr = j_reg[ADDR_W-1:0];
                state_next  = S_SCHK;
            end
            S_SCHK:
            begin
                cmd.rd_addr = j_reg[ADDR_W-1:0];
                if (!stat.match)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRD;
                end
                else if (stat.out_free)
                begin
                    cmd.out_idx = 1'b1;
                    j_next      = j_reg + 1'b1;
                    if (stat.last_emit)
                    begin
                        cmd.clear_set = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end
endmodule

>>> sv/grade_set_mean_median_mode_unit.sv
// Channel  Role    Transaction
// item     sink    one grade plus last flag
// result   source  summary, then one index per grade equal to the mode
//
// Grades load one per cycle. After the last grade the restoring divider forms
// the mean, then a rank pass over the grade RAM (one read port) ranks each
// grade, then the summary and the indexes of grades equal to the mode follow.
// Reset is asynchronous, active low; the grade RAM is not cleared.
// The result register takes a new transaction while the old one is taken;
// a stalled result holds the sequencer, and no grade is taken until the set ends.
`include "grade_set_mean_median_mode_unit_defines.svh"

module grade_set_mean_median_mode_unit (
    input logic       clk,
    input logic       rst_n,
    gsm_in_if.sink    item,
    gsm_out_if.source result
);
    import gsm_pkg::*;

    gsm_cmd_t  cmd;
    gsm_stat_t stat;

    gsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_last  (item.last),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .grade  (item.grade),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // Checks
    `GSM_ASSERT_NXT(a_busy_after_last, item.valid && item.ready && item.last, !item.ready)
    `GSM_ASSERT_IMP(a_summary_not_end, result.valid && (result.kind == KIND_SUMMARY), !result.end_of_run)
    `GSM_ASSERT_IMP(a_mode_count_nonzero, result.valid, result.mode_count != '0)
    `GSM_ASSERT_IMP(a_no_double_load, cmd.load, !cmd.drop && !stat.full)
endmodule
